[hw/rtl/selm_pkg.sv]
// Shared types, codes and sizes of the shared/exclusive lock manager.
`default_nettype none

package selm_pkg;

   // Sizes of the waiter queue and of the hold counter.
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_HOLDS   = 255;

   localparam int ID_W      = 16;
   localparam int CMD_W     = 3;
   localparam int STATUS_W  = 4;
   localparam int MODE_W    = 2;
   localparam int HOLDERS_W = 8;

   localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int HOLD_W = $clog2(MAX_HOLDS + 1);

   // One response per woken waiter plus one for the requester itself.
   localparam int RES_DEPTH = QUEUE_DEPTH + 1;
   localparam int RIDX_W    = $clog2(RES_DEPTH);
   localparam int RCNT_W    = $clog2(RES_DEPTH + 1);

   // Command codes; the remaining codes are answered as a query.
   localparam logic [CMD_W-1:0] CMD_ACQUIRE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_UPGRADE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;

   // Response status codes.
   localparam logic [STATUS_W-1:0] RS_GRANTED     = 4'd0;
   localparam logic [STATUS_W-1:0] RS_QUEUED      = 4'd1;
   localparam logic [STATUS_W-1:0] RS_BUSY        = 4'd2;
   localparam logic [STATUS_W-1:0] RS_FULL        = 4'd3;
   localparam logic [STATUS_W-1:0] RS_WOKEN       = 4'd4;
   localparam logic [STATUS_W-1:0] RS_RELEASED    = 4'd5;
   localparam logic [STATUS_W-1:0] RS_NOT_HELD    = 4'd6;
   localparam logic [STATUS_W-1:0] RS_CANCELLED   = 4'd7;
   localparam logic [STATUS_W-1:0] RS_BAD_UPGRADE = 4'd8;
   localparam logic [STATUS_W-1:0] RS_STATUS      = 4'd9;

   // Lock modes.
   localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SHARED = 2'd1;
   localparam logic [MODE_W-1:0] MODE_EXCL   = 2'd2;

   // Operations on the waiter queue.
   typedef enum logic [2:0] {
      Q_IDLE,
      Q_PUSH,
      Q_POP,
      Q_MOVE,
      Q_TRIM
   } q_op_type;

   typedef struct packed {
      q_op_type            op;
      logic [QIDX_W-1:0]   rd_index;
      logic [QIDX_W-1:0]   wr_index;
      logic [ID_W-1:0]     push_id;
      logic                push_ex;
   } q_ctrl_type;

   typedef struct packed {
      logic [QCNT_W-1:0]   count;
      logic [ID_W-1:0]     rd_id;
      logic                rd_ex;
   } q_stat_type;

   // Response buffer control and head entry.
   typedef struct packed {
      logic                clear;
      logic                wr_en;
      logic                adv;
      logic [ID_W-1:0]     tgt;
      logic [STATUS_W-1:0] st;
      logic                gx;
   } rb_ctrl_type;

   typedef struct packed {
      logic [ID_W-1:0]     tgt;
      logic [STATUS_W-1:0] st;
      logic                gx;
      logic                last;
   } rb_stat_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_ACQ,
      S_DROP,
      S_HEAD,
      S_WAKE,
      S_SCAN,
      S_SHIFT,
      S_EMIT
   } seq_state_type;

endpackage

`default_nettype wire

[hw/rtl/shared_exclusive_lock_manager_top.sv]
// Top level of the shared/exclusive lock manager: sequencer, lock state and channels.
`default_nettype none

// Channel  | Ports                                             | Direction
// ---------+---------------------------------------------------+----------
// request  | req_valid, req_stall, req_command, req_requester, | in
//          | req_want_exclusive, req_no_wait                   |
// response | rsp_valid, rsp_stall, rsp_target, rsp_status,     | out
//          | rsp_granted_exclusive, rsp_lock_state,            |
//          | rsp_holders, rsp_queue_empty, rsp_last            |
//
// One request transaction is handled at a time; req_stall is high from acceptance until the
// last response of that transaction has been taken.
// After acceptance a query, an in-place upgrade or a refused release or upgrade passes the
// decide state before its single response is offered; an acquire passes decide and acquire.
// A release that frees the lock adds the drop state, the head state, which wakes an exclusive
// head waiter, and the wake state, which wakes leading shared waiters one by one; a cancel
// scans the queue for its waiter and shifts the entries behind it. The longest transaction is
// an upgrade that wakes QUEUE_DEPTH shared waiters and then acquires. Each response is held
// while the receiver stalls. The single read/write port of the waiter queue sets this order.
// Reset is synchronous and clears the lock to free with an empty queue; no clearing pass.
module shared_exclusive_lock_manager_top (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [selm_pkg::CMD_W-1:0]    req_command,
   input  wire logic [selm_pkg::ID_W-1:0]     req_requester,
   input  wire logic                          req_want_exclusive,
   input  wire logic                          req_no_wait,

   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [selm_pkg::ID_W-1:0]          rsp_target,
   output logic [selm_pkg::STATUS_W-1:0]      rsp_status,
   output logic                               rsp_granted_exclusive,
   output logic [selm_pkg::MODE_W-1:0]        rsp_lock_state,
   output logic [selm_pkg::HOLDERS_W-1:0]     rsp_holders,
   output logic                               rsp_queue_empty,
   output logic                               rsp_last
);

   selm_pkg::seq_state_type     state_ff, state_in;
   logic [selm_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [selm_pkg::HOLD_W-1:0] hold_ff, hold_in;
   logic [selm_pkg::ID_W-1:0]   owner_ff, owner_in;
   logic [selm_pkg::QCNT_W-1:0] idx_ff, idx_in;
   logic [selm_pkg::QCNT_W-1:0] idx_next;

   // Captured request transaction.
   logic [selm_pkg::CMD_W-1:0]  cmd_ff;
   logic [selm_pkg::ID_W-1:0]   req_id_ff;
   logic                        ex_ff;
   logic                        nw_ff;

   selm_pkg::q_ctrl_type        q_ctrl;
   selm_pkg::q_stat_type        q_stat;
   selm_pkg::rb_ctrl_type       rb_ctrl;
   selm_pkg::rb_stat_type       rb_stat;

   logic                        req_accept;
   logic                        rsp_accept;
   logic                        is_upgrade;
   logic                        acq_ex;
   logic                        acq_nw;
   logic                        hold_at_max;
   logic                        queue_full;
   logic                        queue_empty;
   selm_pkg::seq_state_type     after_drop;

   selm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_ctrl (q_ctrl),
      .q_stat (q_stat)
   );

   selm_rbuf u_rbuf (
      .clock   (clock),
      .reset   (reset),
      .rb_ctrl (rb_ctrl),
      .rb_stat (rb_stat)
   );

   assign req_stall  = (state_ff != selm_pkg::S_IDLE);
   assign rsp_valid  = (state_ff == selm_pkg::S_EMIT);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   // An upgrade that cannot convert in place continues as an exclusive acquire that waits.
   assign is_upgrade  = (cmd_ff == selm_pkg::CMD_UPGRADE);
   assign acq_ex      = is_upgrade ? 1'b1 : ex_ff;
   assign acq_nw      = is_upgrade ? 1'b0 : nw_ff;
   assign hold_at_max = (hold_ff >= selm_pkg::HOLD_W'(selm_pkg::MAX_HOLDS));
   assign queue_full  = (q_stat.count >= selm_pkg::QCNT_W'(selm_pkg::QUEUE_DEPTH));
   assign queue_empty = (q_stat.count == '0);
   assign after_drop  = is_upgrade ? selm_pkg::S_ACQ : selm_pkg::S_EMIT;
   assign idx_next    = idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= selm_pkg::S_IDLE;
         mode_ff  <= selm_pkg::MODE_NONE;
         hold_ff  <= '0;
         owner_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         hold_ff  <= hold_in;
         owner_ff <= owner_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff    <= req_command;
         req_id_ff <= req_requester;
         ex_ff     <= req_want_exclusive;
         nw_ff     <= req_no_wait;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      hold_in  = hold_ff;
      owner_in = owner_ff;
      idx_in   = idx_ff;

      q_ctrl          = '0;
      q_ctrl.op       = selm_pkg::Q_IDLE;
      q_ctrl.push_id  = req_id_ff;
      q_ctrl.push_ex  = acq_ex;

      rb_ctrl     = '0;
      rb_ctrl.tgt = req_id_ff;

      unique case (state_ff)
         selm_pkg::S_IDLE: begin
            if (req_accept) begin
               rb_ctrl.clear = 1'b1;
               state_in      = selm_pkg::S_DECIDE;
            end
         end

         selm_pkg::S_DECIDE: begin
            unique case (cmd_ff)
               selm_pkg::CMD_ACQUIRE: begin
                  state_in = selm_pkg::S_ACQ;
               end
               selm_pkg::CMD_RELEASE: begin
                  rb_ctrl.wr_en = 1'b1;
                  if (hold_ff == '0) begin
                     rb_ctrl.st = selm_pkg::RS_NOT_HELD;
                     state_in   = selm_pkg::S_EMIT;
                  end else begin
                     rb_ctrl.st = selm_pkg::RS_RELEASED;
                     state_in   = selm_pkg::S_DROP;
                  end
               end
               selm_pkg::CMD_UPGRADE: begin
                  if (hold_ff == '0 || mode_ff != selm_pkg::MODE_SHARED) begin
                     rb_ctrl.wr_en = 1'b1;
                     rb_ctrl.st    = selm_pkg::RS_BAD_UPGRADE;
                     state_in      = selm_pkg::S_EMIT;
                  end else if (hold_ff == selm_pkg::HOLD_W'(1) && queue_empty) begin
                     mode_in       = selm_pkg::MODE_EXCL;
                     owner_in      = req_id_ff;
                     rb_ctrl.wr_en = 1'b1;
                     rb_ctrl.st    = selm_pkg::RS_GRANTED;
                     rb_ctrl.gx    = 1'b1;
                     state_in      = selm_pkg::S_EMIT;
                  end else if (nw_ff) begin
                     rb_ctrl.wr_en = 1'b1;
                     rb_ctrl.st    = selm_pkg::RS_BUSY;
                     state_in      = selm_pkg::S_EMIT;
                  end else begin
                     state_in = selm_pkg::S_DROP;
                  end
               end
               selm_pkg::CMD_CANCEL: begin
                  idx_in   = '0;
                  state_in = selm_pkg::S_SCAN;
               end
               default: begin
                  // Query and the unused command codes.
                  rb_ctrl.wr_en = 1'b1;
                  rb_ctrl.st    = selm_pkg::RS_STATUS;
                  rb_ctrl.gx    = (mode_ff == selm_pkg::MODE_EXCL) && (owner_ff == req_id_ff);
                  state_in      = selm_pkg::S_EMIT;
               end
            endcase
         end

         selm_pkg::S_ACQ: begin
            rb_ctrl.wr_en = 1'b1;
            state_in      = selm_pkg::S_EMIT;
            if (hold_ff == '0) begin
               mode_in    = acq_ex ? selm_pkg::MODE_EXCL : selm_pkg::MODE_SHARED;
               owner_in   = acq_ex ? req_id_ff : '0;
               hold_in    = selm_pkg::HOLD_W'(1);
               rb_ctrl.st = selm_pkg::RS_GRANTED;
               rb_ctrl.gx = acq_ex;
            end else if (mode_ff == selm_pkg::MODE_EXCL && owner_ff == req_id_ff) begin
               // Re-entry by the owner is always exclusive.
               if (hold_at_max) begin
                  rb_ctrl.st = selm_pkg::RS_FULL;
               end else begin
                  hold_in    = hold_ff + 1'b1;
                  rb_ctrl.st = selm_pkg::RS_GRANTED;
                  rb_ctrl.gx = 1'b1;
               end
            end else if (mode_ff == selm_pkg::MODE_SHARED && !acq_ex && queue_empty) begin
               if (hold_at_max) begin
                  rb_ctrl.st = selm_pkg::RS_FULL;
               end else begin
                  hold_in    = hold_ff + 1'b1;
                  rb_ctrl.st = selm_pkg::RS_GRANTED;
               end
            end else if (acq_nw) begin
               rb_ctrl.st = selm_pkg::RS_BUSY;
            end else if (queue_full) begin
               rb_ctrl.st = selm_pkg::RS_FULL;
            end else begin
               q_ctrl.op  = selm_pkg::Q_PUSH;
               rb_ctrl.st = selm_pkg::RS_QUEUED;
            end
         end

         selm_pkg::S_DROP: begin
            hold_in = hold_ff - 1'b1;
            if (hold_ff == selm_pkg::HOLD_W'(1)) begin
               mode_in  = selm_pkg::MODE_NONE;
               owner_in = '0;
               state_in = selm_pkg::S_HEAD;
            end else begin
               state_in = after_drop;
            end
         end

         selm_pkg::S_HEAD: begin
            // The lock just became free: hand it to the head of the queue.
            q_ctrl.rd_index = '0;
            if (queue_empty) begin
               state_in = after_drop;
            end else if (q_stat.rd_ex) begin
               q_ctrl.op     = selm_pkg::Q_POP;
               mode_in       = selm_pkg::MODE_EXCL;
               hold_in       = selm_pkg::HOLD_W'(1);
               owner_in      = q_stat.rd_id;
               rb_ctrl.wr_en = 1'b1;
               rb_ctrl.tgt   = q_stat.rd_id;
               rb_ctrl.st    = selm_pkg::RS_WOKEN;
               rb_ctrl.gx    = 1'b1;
               state_in      = after_drop;
            end else begin
               state_in = selm_pkg::S_WAKE;
            end
         end

         selm_pkg::S_WAKE: begin
            // Wake the run of leading shared waiters one per cycle, up to the hold limit.
            q_ctrl.rd_index = '0;
            if (!queue_empty && !q_stat.rd_ex && !hold_at_max) begin
               q_ctrl.op     = selm_pkg::Q_POP;
               mode_in       = selm_pkg::MODE_SHARED;
               hold_in       = hold_ff + 1'b1;
               rb_ctrl.wr_en = 1'b1;
               rb_ctrl.tgt   = q_stat.rd_id;
               rb_ctrl.st    = selm_pkg::RS_WOKEN;
            end else begin
               state_in = after_drop;
            end
         end

         selm_pkg::S_SCAN: begin
            q_ctrl.rd_index = idx_ff[selm_pkg::QIDX_W-1:0];
            if (idx_ff == q_stat.count) begin
               rb_ctrl.wr_en = 1'b1;
               rb_ctrl.st    = selm_pkg::RS_NOT_HELD;
               state_in      = selm_pkg::S_EMIT;
            end else if (q_stat.rd_id == req_id_ff) begin
               state_in = selm_pkg::S_SHIFT;
            end else begin
               idx_in = idx_next;
            end
         end

         selm_pkg::S_SHIFT: begin
            // Close the gap left by the cancelled waiter, one entry per cycle.
            q_ctrl.rd_index = idx_next[selm_pkg::QIDX_W-1:0];
            q_ctrl.wr_index = idx_ff[selm_pkg::QIDX_W-1:0];
            if (idx_next < q_stat.count) begin
               q_ctrl.op = selm_pkg::Q_MOVE;
               idx_in    = idx_next;
            end else begin
               q_ctrl.op     = selm_pkg::Q_TRIM;
               rb_ctrl.wr_en = 1'b1;
               rb_ctrl.st    = selm_pkg::RS_CANCELLED;
               state_in      = selm_pkg::S_EMIT;
            end
         end

         selm_pkg::S_EMIT: begin
            if (rsp_accept) begin
               rb_ctrl.adv = 1'b1;
               if (rb_stat.last) begin
                  state_in = selm_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = selm_pkg::S_IDLE;
         end
      endcase
   end

   // Every response of a transaction reports the lock as it stands after the transaction.
   assign rsp_target            = rb_stat.tgt;
   assign rsp_status            = rb_stat.st;
   assign rsp_granted_exclusive = rb_stat.gx;
   assign rsp_lock_state        = mode_ff;
   assign rsp_holders           = selm_pkg::HOLDERS_W'(hold_ff);
   assign rsp_queue_empty       = queue_empty;
   assign rsp_last              = rb_stat.last;

   // A free lock has no mode.
   a_free_means_none: assert property (@(posedge clock) disable iff (reset)
      (hold_ff == '0) |-> (mode_ff == selm_pkg::MODE_NONE))
      else $error("lock mode set while no hold is counted");

   // An owner is recorded only for an exclusive lock.
   a_owner_only_excl: assert property (@(posedge clock) disable iff (reset)
      (mode_ff != selm_pkg::MODE_EXCL) |-> (owner_ff == '0))
      else $error("exclusive owner kept outside exclusive mode");

   // Between transactions nobody waits on a free lock.
   a_no_wait_on_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == selm_pkg::S_IDLE && !queue_empty) |-> (hold_ff != '0))
      else $error("waiters left queued on a free lock");

   // Taking the last response frees the request channel in the next cycle.
   a_last_frees_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_last) |=> !req_stall)
      else $error("request channel still stalled after the last response");

endmodule

`default_nettype wire

[hw/rtl/selm_queue.sv]
// Circular waiter queue with one read port and one write port by logical index.
`default_nettype none

module selm_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire selm_pkg::q_ctrl_type q_ctrl,
   output selm_pkg::q_stat_type     q_stat
);

   logic [selm_pkg::ID_W-1:0]   wait_ids_ff [selm_pkg::QUEUE_DEPTH];
   logic                        wait_ex_ff  [selm_pkg::QUEUE_DEPTH];
   logic [selm_pkg::QIDX_W-1:0] head_ff, head_in;
   logic [selm_pkg::QCNT_W-1:0] count_ff, count_in;
   logic [selm_pkg::QIDX_W-1:0] rd_phys, wr_phys;

   // Logical position to physical slot; the sum stays below twice the depth.
   function automatic logic [selm_pkg::QIDX_W-1:0] wrap_index(
      input logic [selm_pkg::QIDX_W-1:0] base,
      input logic [selm_pkg::QIDX_W-1:0] offset
   );
      logic [selm_pkg::QIDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offset};
      if (sum >= (selm_pkg::QIDX_W + 1)'(selm_pkg::QUEUE_DEPTH)) begin
         sum = sum - (selm_pkg::QIDX_W + 1)'(selm_pkg::QUEUE_DEPTH);
      end
      return sum[selm_pkg::QIDX_W-1:0];
   endfunction

   always_comb begin
      rd_phys = wrap_index(head_ff, q_ctrl.rd_index);
      if (q_ctrl.op == selm_pkg::Q_PUSH) begin
         wr_phys = wrap_index(head_ff, count_ff[selm_pkg::QIDX_W-1:0]);
      end else begin
         wr_phys = wrap_index(head_ff, q_ctrl.wr_index);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      unique case (q_ctrl.op)
         selm_pkg::Q_PUSH: begin
            count_in = count_ff + 1'b1;
         end
         selm_pkg::Q_POP: begin
            if (head_ff == selm_pkg::QIDX_W'(selm_pkg::QUEUE_DEPTH - 1)) begin
               head_in = '0;
            end else begin
               head_in = head_ff + 1'b1;
            end
            count_in = count_ff - 1'b1;
         end
         selm_pkg::Q_TRIM: begin
            count_in = count_ff - 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_ctrl.op == selm_pkg::Q_PUSH) begin
         wait_ids_ff[wr_phys] <= q_ctrl.push_id;
         wait_ex_ff[wr_phys]  <= q_ctrl.push_ex;
      end else if (q_ctrl.op == selm_pkg::Q_MOVE) begin
         wait_ids_ff[wr_phys] <= wait_ids_ff[rd_phys];
         wait_ex_ff[wr_phys]  <= wait_ex_ff[rd_phys];
      end
   end

   assign q_stat.count = count_ff;
   assign q_stat.rd_id = wait_ids_ff[rd_phys];
   assign q_stat.rd_ex = wait_ex_ff[rd_phys];

endmodule

`default_nettype wire

[hw/rtl/selm_rbuf.sv]
// Response buffer that collects the responses of one transaction before they are sent.
`default_nettype none

module selm_rbuf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire selm_pkg::rb_ctrl_type rb_ctrl,
   output selm_pkg::rb_stat_type     rb_stat
);

   logic [selm_pkg::ID_W-1:0]     res_tgt_ff [selm_pkg::RES_DEPTH];
   logic [selm_pkg::STATUS_W-1:0] res_st_ff  [selm_pkg::RES_DEPTH];
   logic                          res_gx_ff  [selm_pkg::RES_DEPTH];
   logic [selm_pkg::RCNT_W-1:0]   wr_cnt_ff, wr_cnt_in;
   logic [selm_pkg::RIDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic                          wr_ok;

   assign wr_ok = rb_ctrl.wr_en && (wr_cnt_ff < selm_pkg::RCNT_W'(selm_pkg::RES_DEPTH));

   always_comb begin
      wr_cnt_in = wr_cnt_ff;
      rd_ptr_in = rd_ptr_ff;
      if (rb_ctrl.clear) begin
         wr_cnt_in = '0;
         rd_ptr_in = '0;
      end else begin
         if (wr_ok) begin
            wr_cnt_in = wr_cnt_ff + 1'b1;
         end
         if (rb_ctrl.adv) begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_cnt_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_cnt_ff <= wr_cnt_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok && !rb_ctrl.clear) begin
         res_tgt_ff[wr_cnt_ff[selm_pkg::RIDX_W-1:0]] <= rb_ctrl.tgt;
         res_st_ff[wr_cnt_ff[selm_pkg::RIDX_W-1:0]]  <= rb_ctrl.st;
         res_gx_ff[wr_cnt_ff[selm_pkg::RIDX_W-1:0]]  <= rb_ctrl.gx;
      end
   end

   assign rb_stat.tgt  = res_tgt_ff[rd_ptr_ff];
   assign rb_stat.st   = res_st_ff[rd_ptr_ff];
   assign rb_stat.gx   = res_gx_ff[rd_ptr_ff];
   assign rb_stat.last = (selm_pkg::RCNT_W'(rd_ptr_ff) + selm_pkg::RCNT_W'(1)) == wr_cnt_ff;

endmodule

`default_nettype wire

[sim/tb_shared_exclusive_lock_manager_top.sv]
// Self-checking testbench for the shared/exclusive lock manager top level.
`timescale 1ns / 1ps

module tb_shared_exclusive_lock_manager_top;

   // Command codes above the query are spare and must be answered as a query.
   localparam logic [selm_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [selm_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   // The receiver holds off this long once, well inside the watchdog limit.
   localparam int PRESS_CYCLES = 300;
   localparam int STUCK_LIMIT  = 2000;
   // Worst-case sequencing of one transaction, with margin, for the final drain.
   localparam int DRAIN_CYCLES = 2 * selm_pkg::QUEUE_DEPTH + 40;
   localparam int RANDOM_ITEMS = 90;

   // One expected or observed response transaction.
   typedef struct packed {
      logic [selm_pkg::ID_W-1:0]      tgt;
      logic [selm_pkg::STATUS_W-1:0]  st;
      logic                           gx;
      logic [selm_pkg::MODE_W-1:0]    mode;
      logic [selm_pkg::HOLDERS_W-1:0] holders;
      logic                           qempty;
      logic                           last;
   } lock_resp_type;

   // The ledger mirrors the lock: mode, hold count, exclusive owner and the FIFO of
   // waiters. Every accepted request is applied to it, and the responses that the
   // request must cause are queued in order for comparison with the DUT.
   class lock_ledger;
      logic [selm_pkg::MODE_W-1:0] lock_mode;
      int                          hold_cnt;
      logic [selm_pkg::ID_W-1:0]   owner;
      logic [selm_pkg::ID_W-1:0]   wait_id[$];
      bit                          wait_ex[$];
      lock_resp_type               step_resps[$];
      lock_resp_type               due_responses[$];
      int                          errors;
      int                          n_requests;
      int                          n_responses;
      int                          n_woken;
      int                          n_full;

      function new();
         lock_mode   = selm_pkg::MODE_NONE;
         hold_cnt    = 0;
         owner       = '0;
         errors      = 0;
         n_requests  = 0;
         n_responses = 0;
         n_woken     = 0;
         n_full      = 0;
      endfunction

      function void emit(logic [selm_pkg::ID_W-1:0] tgt, logic [selm_pkg::STATUS_W-1:0] st,
                         logic gx);
         lock_resp_type r;
         r     = '0;
         r.tgt = tgt;
         r.st  = st;
         r.gx  = gx;
         step_resps.push_back(r);
         if (st == selm_pkg::RS_WOKEN) n_woken++;
         if (st == selm_pkg::RS_FULL) n_full++;
      endfunction

      // Drops one hold; at zero the head exclusive waiter, or the run of leading
      // shared waiters, is granted.
      function void drop_hold();
         logic [selm_pkg::ID_W-1:0] id;
         if (hold_cnt == 0) return;
         hold_cnt--;
         if (hold_cnt != 0) return;
         lock_mode = selm_pkg::MODE_NONE;
         owner     = '0;
         if (wait_id.size() == 0) return;
         if (wait_ex[0]) begin
            id = wait_id.pop_front();
            void'(wait_ex.pop_front());
            lock_mode = selm_pkg::MODE_EXCL;
            hold_cnt  = 1;
            owner     = id;
            emit(id, selm_pkg::RS_WOKEN, 1'b1);
         end else begin
            while (wait_id.size() != 0 && !wait_ex[0] && hold_cnt < selm_pkg::MAX_HOLDS) begin
               id = wait_id.pop_front();
               void'(wait_ex.pop_front());
               lock_mode = selm_pkg::MODE_SHARED;
               hold_cnt++;
               emit(id, selm_pkg::RS_WOKEN, 1'b0);
            end
         end
      endfunction

      function void take_lock(logic [selm_pkg::ID_W-1:0] id, bit ex, bit nw);
         if (hold_cnt == 0) begin
            lock_mode = ex ? selm_pkg::MODE_EXCL : selm_pkg::MODE_SHARED;
            owner     = ex ? id : '0;
            hold_cnt  = 1;
            emit(id, selm_pkg::RS_GRANTED, ex);
         end else if (lock_mode == selm_pkg::MODE_EXCL && owner == id) begin
            // Re-entry is always exclusive, whatever mode was asked for.
            if (hold_cnt >= selm_pkg::MAX_HOLDS) begin
               emit(id, selm_pkg::RS_FULL, 1'b0);
            end else begin
               hold_cnt++;
               emit(id, selm_pkg::RS_GRANTED, 1'b1);
            end
         end else if (lock_mode == selm_pkg::MODE_SHARED && !ex && wait_id.size() == 0) begin
            if (hold_cnt >= selm_pkg::MAX_HOLDS) begin
               emit(id, selm_pkg::RS_FULL, 1'b0);
            end else begin
               hold_cnt++;
               emit(id, selm_pkg::RS_GRANTED, 1'b0);
            end
         end else if (nw) begin
            emit(id, selm_pkg::RS_BUSY, 1'b0);
         end else if (wait_id.size() >= selm_pkg::QUEUE_DEPTH) begin
            emit(id, selm_pkg::RS_FULL, 1'b0);
         end else begin
            wait_id.push_back(id);
            wait_ex.push_back(ex);
            emit(id, selm_pkg::RS_QUEUED, 1'b0);
         end
      endfunction

      function void note_request(logic [selm_pkg::CMD_W-1:0] cmd,
                                 logic [selm_pkg::ID_W-1:0] id, bit ex, bit nw);
         bit found;
         found = 1'b0;
         n_requests++;
         case (cmd)
            selm_pkg::CMD_ACQUIRE: take_lock(id, ex, nw);
            selm_pkg::CMD_RELEASE: begin
               if (hold_cnt == 0) begin
                  emit(id, selm_pkg::RS_NOT_HELD, 1'b0);
               end else begin
                  emit(id, selm_pkg::RS_RELEASED, 1'b0);
                  drop_hold();
               end
            end
            selm_pkg::CMD_UPGRADE: begin
               if (hold_cnt == 0 || lock_mode != selm_pkg::MODE_SHARED) begin
                  emit(id, selm_pkg::RS_BAD_UPGRADE, 1'b0);
               end else if (hold_cnt == 1 && wait_id.size() == 0) begin
                  lock_mode = selm_pkg::MODE_EXCL;
                  owner     = id;
                  emit(id, selm_pkg::RS_GRANTED, 1'b1);
               end else if (nw) begin
                  emit(id, selm_pkg::RS_BUSY, 1'b0);
               end else begin
                  drop_hold();
                  take_lock(id, 1'b1, 1'b0);
               end
            end
            selm_pkg::CMD_CANCEL: begin
               for (int i = 0; i < wait_id.size(); i++) begin
                  if (wait_id[i] == id) begin
                     wait_id.delete(i);
                     wait_ex.delete(i);
                     found = 1'b1;
                     break;
                  end
               end
               emit(id, found ? selm_pkg::RS_CANCELLED : selm_pkg::RS_NOT_HELD, 1'b0);
            end
            default: emit(id, selm_pkg::RS_STATUS,
                          lock_mode == selm_pkg::MODE_EXCL && owner == id);
         endcase
         // Every response of the step reports the state after the whole step.
         foreach (step_resps[k]) begin
            step_resps[k].mode    = lock_mode;
            step_resps[k].holders = hold_cnt[selm_pkg::HOLDERS_W-1:0];
            step_resps[k].qempty  = wait_id.size() == 0;
            step_resps[k].last    = k == step_resps.size() - 1;
            due_responses.push_back(step_resps[k]);
         end
         step_resps.delete();
      endfunction

      function void compare(string name, logic [selm_pkg::ID_W-1:0] exp_v,
                            logic [selm_pkg::ID_W-1:0] act_v);
         if (act_v !== exp_v) begin
            errors++;
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_response(lock_resp_type act);
         lock_resp_type exp_r;
         n_responses++;
         if (due_responses.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual target %0h status %0d",
                     $time, act.tgt, act.st);
            return;
         end
         exp_r = due_responses.pop_front();
         compare("target", exp_r.tgt, act.tgt);
         compare("status", exp_r.st, act.st);
         compare("granted_exclusive", exp_r.gx, act.gx);
         compare("lock_state", exp_r.mode, act.mode);
         compare("holders", exp_r.holders, act.holders);
         compare("queue_empty", exp_r.qempty, act.qempty);
         compare("last", exp_r.last, act.last);
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [selm_pkg::CMD_W-1:0]     req_command = selm_pkg::CMD_QUERY;
   logic [selm_pkg::ID_W-1:0]      req_requester = '0;
   logic                           req_want_exclusive = 1'b0;
   logic                           req_no_wait = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [selm_pkg::ID_W-1:0]      rsp_target;
   logic [selm_pkg::STATUS_W-1:0]  rsp_status;
   logic                           rsp_granted_exclusive;
   logic [selm_pkg::MODE_W-1:0]    rsp_lock_state;
   logic [selm_pkg::HOLDERS_W-1:0] rsp_holders;
   logic                           rsp_queue_empty;
   logic                           rsp_last;

   // Phase controls of the sender and the receiver; calm is shared by both.
   logic calm = 1'b0;
   logic press_start = 1'b0;
   bit   press_done = 1'b0;

   logic [selm_pkg::ID_W-1:0] id_pool[6];
   lock_ledger                ledger = new();

   shared_exclusive_lock_manager_top i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_command           (req_command),
      .req_requester         (req_requester),
      .req_want_exclusive    (req_want_exclusive),
      .req_no_wait           (req_no_wait),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_target            (rsp_target),
      .rsp_status            (rsp_status),
      .rsp_granted_exclusive (rsp_granted_exclusive),
      .rsp_lock_state        (rsp_lock_state),
      .rsp_holders           (rsp_holders),
      .rsp_queue_empty       (rsp_queue_empty),
      .rsp_last              (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one request transaction and returns at the edge that accepts it. The sender
   // may idle first; valid is never lowered and raised in the same time step, and the
   // payload holds still while the block stalls.
   task automatic send_request(logic [selm_pkg::CMD_W-1:0] cmd, logic [selm_pkg::ID_W-1:0] id,
                               bit ex, bit nw);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_requester      <= id;
      req_want_exclusive <= ex;
      req_no_wait        <= nw;
      do @(posedge clock); while (req_stall);
      ledger.note_request(cmd, id, ex, nw);
   endtask

   // Releases until the lock is free; the hold count seen here is already up to date
   // because the ledger is updated at each acceptance.
   task automatic release_all(logic [selm_pkg::ID_W-1:0] id);
      while (ledger.hold_cnt != 0) send_request(selm_pkg::CMD_RELEASE, id, 1'b0, 1'b0);
   endtask

   // Random traffic mostly uses a small pool of requesters so that re-entry, cancels
   // that hit, and deep waiter queues are common; the rest use any identifier.
   task automatic send_random_request();
      logic [selm_pkg::CMD_W-1:0] cmd;
      logic [selm_pkg::ID_W-1:0]  id;
      int unsigned                pick;
      pick = $urandom_range(0, 99);
      if (pick < 38) cmd = selm_pkg::CMD_ACQUIRE;
      else if (pick < 60) cmd = selm_pkg::CMD_RELEASE;
      else if (pick < 70) cmd = selm_pkg::CMD_UPGRADE;
      else if (pick < 82) cmd = selm_pkg::CMD_CANCEL;
      else if (pick < 92) cmd = selm_pkg::CMD_QUERY;
      else cmd = selm_pkg::CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      if ($urandom_range(0, 99) < 80) id = id_pool[$urandom_range(0, 5)];
      else id = selm_pkg::ID_W'($urandom_range(0, 65535));
      send_request(cmd, id, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 25);
   endtask

   // The receiver stalls at random, not at all during the calm stretch, and once holds
   // off for a long run of cycles so that the block backs up into its request side.
   initial begin
      forever begin
         @(posedge clock);
         if (press_start && !press_done) begin
            press_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESS_CYCLES) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
   end

   // Every accepted response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_response({rsp_target, rsp_status, rsp_granted_exclusive,
                                rsp_lock_state, rsp_holders, rsp_queue_empty, rsp_last});
   end

   // Watchdog: ends the run when neither channel has accepted anything for too long.
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
      end
      $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
      $display("tb_shared_exclusive_lock_manager_top failed");
      $finish;
   end

   initial begin
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 6; i++) id_pool[i] = selm_pkg::ID_W'($urandom_range(1, 65534));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the free lock, requester zero and the all-ones requester,
      // upgrades in place, refused and queued, cancels, re-entry, spare commands and
      // release by a requester that holds nothing.
      send_request(selm_pkg::CMD_RELEASE, 16'h0001, 1'b0, 1'b0);   // release of a free lock
      send_request(selm_pkg::CMD_UPGRADE, 16'h0001, 1'b1, 1'b0);   // upgrade, no shared hold
      send_request(selm_pkg::CMD_CANCEL, 16'h0001, 1'b0, 1'b0);    // cancel, nobody waiting
      send_request(selm_pkg::CMD_QUERY, 16'h0000, 1'b0, 1'b0);
      send_request(selm_pkg::CMD_ACQUIRE, 16'h0000, 1'b0, 1'b0);   // requester zero
      send_request(selm_pkg::CMD_ACQUIRE, 16'hFFFF, 1'b0, 1'b1);   // shared join
      send_request(selm_pkg::CMD_UPGRADE, 16'hFFFF, 1'b0, 1'b1);   // no_wait: busy
      send_request(selm_pkg::CMD_UPGRADE, 16'hFFFF, 1'b1, 1'b0);   // drops a hold, queues
      send_request(selm_pkg::CMD_ACQUIRE, 16'h1234, 1'b0, 1'b0);   // shared behind a waiter
      send_request(selm_pkg::CMD_ACQUIRE, 16'h1234, 1'b0, 1'b1);
      send_request(selm_pkg::CMD_ACQUIRE, 16'h5555, 1'b1, 1'b0);
      send_request(selm_pkg::CMD_ACQUIRE, 16'h1234, 1'b1, 1'b0);   // duplicate waiter
      send_request(selm_pkg::CMD_CANCEL, 16'h1234, 1'b0, 1'b0);    // first entry only
      send_request(selm_pkg::CMD_RELEASE, 16'h0000, 1'b0, 1'b0);   // wakes exclusive head
      send_request(selm_pkg::CMD_ACQUIRE, 16'hFFFF, 1'b0, 1'b0);   // re-entry asking shared
      send_request(selm_pkg::CMD_QUERY, 16'hFFFF, 1'b0, 1'b0);
      send_request(CMD_SPARE_FIRST, 16'hFFFF, 1'b1, 1'b1);
      send_request(CMD_SPARE_LAST, 16'hAAAA, 1'b0, 1'b0);
      send_request(selm_pkg::CMD_RELEASE, 16'hAAAA, 1'b0, 1'b0);   // any requester releases
      send_request(selm_pkg::CMD_RELEASE, 16'hAAAA, 1'b0, 1'b0);
      send_request(selm_pkg::CMD_UPGRADE, 16'h5555, 1'b1, 1'b0);   // upgrade of exclusive
      send_request(selm_pkg::CMD_RELEASE, 16'h5555, 1'b0, 1'b0);   // wakes duplicate waiter
      release_all(16'h5555);
      send_request(selm_pkg::CMD_ACQUIRE, 16'h8000, 1'b0, 1'b0);
      send_request(selm_pkg::CMD_UPGRADE, 16'h8000, 1'b0, 1'b0);   // in-place upgrade
      release_all(16'h8000);

      // Full queue: sixteen shared waiters behind an exclusive holder, an exclusive request is
      // refused as full, a no-wait one as busy, and the release wakes all in one transaction.
      send_request(selm_pkg::CMD_ACQUIRE, id_pool[2], 1'b1, 1'b0);
      for (int i = 0; i < selm_pkg::QUEUE_DEPTH; i++)
         send_request(selm_pkg::CMD_ACQUIRE, selm_pkg::ID_W'($urandom_range(0, 65535)),
                      1'b0, 1'b0);
      send_request(selm_pkg::CMD_ACQUIRE, id_pool[3], 1'b1, 1'b0);
      send_request(selm_pkg::CMD_ACQUIRE, id_pool[3], 1'b0, 1'b1);
      send_request(selm_pkg::CMD_RELEASE, id_pool[2], 1'b0, 1'b0);
      release_all(id_pool[3]);

      // Random part, with one long stretch free of idling on both sides and one long
      // receiver hold-off early on.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 10) press_start <= 1'b1;
         if (n == 30) calm <= 1'b1;
         if (n == 65) calm <= 1'b0;
         send_random_request();
      end
      req_valid <= 1'b0;

      while (ledger.due_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request and %0d response transactions,", ledger.n_requests,
               ledger.n_responses);
      $display("with %0d woken waiters and %0d full-queue or hold-overflow refusals.",
               ledger.n_woken, ledger.n_full);
      if (ledger.errors == 0) begin
         $display("tb_shared_exclusive_lock_manager_top passed");
      end else begin
         $display("tb_shared_exclusive_lock_manager_top failed");
      end
      $finish;
   end

endmodule
